// ===== hw/rtl/tef_pkg.sv =====
// Shared types, constants and per-character framing functions for the telegram framer.
`default_nettype none
package tef_pkg;

  // Escape phase codes
  localparam logic [2:0] PH_WANT1      = 3'd1;
  localparam logic [2:0] PH_WANT2      = 3'd2;
  localparam logic [2:0] PH_WANT_CLOSE = 3'd3;
  localparam logic [2:0] PH_OVERRUN    = 3'd4;
  localparam logic [2:0] PH_PLAIN      = 3'd5;

  // Character and checksum constants
  localparam logic [7:0] CHK_INIT = 8'h7F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [4:0] HEX_BAD  = 5'd16;

  // Result queue sizing
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int LEVEL_W     = 3;
  localparam int CNT_W       = 2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } tef_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_telegram;
  } tef_out_t;

  typedef struct packed {
    logic [2:0] escape_phase;
    logic [7:0] first_digit;
    logic [7:0] second_digit;
    logic [7:0] running_checksum;
  } tef_state_t;

  // Results of one accepted item, packed to the front of the list
  typedef struct packed {
    logic [CNT_W-1:0]             cnt;
    tef_out_t [MAX_RESULTS-1:0]   item;
  } tef_push_t;

  // Queue status towards the top level
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
  } tef_qstat_t;

  // Outcome of feeding one character
  typedef struct packed {
    tef_state_t st;
    logic       emit;
    logic [7:0] value;
  } tef_feed_t;

  localparam tef_state_t STATE_RESET = '{
    escape_phase:     PH_PLAIN,
    first_digit:      CH_NUL,
    second_digit:     CH_NUL,
    running_checksum: CHK_INIT
  };

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = HEX_BAD;
    if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h61 + 8'd10);
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Two-character hex decode: skip blanks, optional sign, digits up to a non-digit
  function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] s [3];
    logic [1:0] i;
    logic [7:0] v;
    logic       neg;
    logic       stop;
    logic [4:0] h;
    s[0] = a;
    s[1] = b;
    s[2] = CH_NUL;
    i    = 2'd0;
    v    = 8'd0;
    neg  = 1'b0;
    stop = 1'b0;
    if (is_blank(s[0])) begin
      i = 2'd1;
      if (is_blank(s[1])) i = 2'd2;
    end
    if (i < 2'd2 && (s[i] == CH_PLUS || s[i] == CH_MINUS)) begin
      neg = (s[i] == CH_MINUS);
      i   = i + 2'd1;
    end
    for (int k = 0; k < 2; k++) begin
      h = hex_value(s[i]);
      if (!stop && i < 2'd2 && h != HEX_BAD) begin
        v = {v[3:0], h[3:0]};
        i = i + 2'd1;
      end else begin
        stop = 1'b1;
      end
    end
    if (neg) v = ~v + 8'd1;
    return v;
  endfunction

  // One character through the escape machine
  function automatic tef_feed_t feed(input tef_state_t st, input logic [7:0] c);
    tef_feed_t  r;
    logic       in_esc;
    logic       close;
    logic [7:0] dv;
    r.st    = st;
    r.emit  = 1'b0;
    r.value = c;
    close   = 1'b0;
    in_esc  = (st.escape_phase >= PH_WANT1) && (st.escape_phase <= PH_OVERRUN);
    dv      = decode_pair(st.first_digit, st.second_digit);
    if (c == CH_OPEN) begin
      r.st.escape_phase = PH_WANT1;
    end else if (c == CH_CLOSE && in_esc) begin
      close = 1'b1;
    end else begin
      case (st.escape_phase)
        PH_WANT1: begin
          r.st.first_digit  = c;
          r.st.escape_phase = PH_WANT2;
        end
        PH_WANT2: begin
          r.st.second_digit = c;
          r.st.escape_phase = PH_WANT_CLOSE;
        end
        PH_WANT_CLOSE: r.st.escape_phase = PH_OVERRUN;
        PH_OVERRUN:    close = 1'b1;
        default: begin
          r.st.running_checksum = st.running_checksum ^ c;
          r.emit                = 1'b1;
          r.st.escape_phase     = PH_PLAIN;
        end
      endcase
    end
    if (close) begin
      r.st.running_checksum = st.running_checksum ^ dv;
      r.emit                = 1'b1;
      r.value               = dv;
      r.st.first_digit      = CH_NUL;
      r.st.second_digit     = CH_NUL;
      r.st.escape_phase     = PH_PLAIN;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/telegram_escape_xor_framer_unit.sv =====
// Top level of the telegram framer: escape decoding, XOR checksum and result queue.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one text byte per item, with
//   last_byte marking the final character of a command text. Output channel
//   out_valid/out_ready/out_data carries the framed telegram one byte per item;
//   end_of_telegram is set on the closing checksum byte.
//   Results of an accepted item go into the registered result queue.
//   Throughput: one input item per cycle while each item yields at most one
//   byte and out_ready stays high; a last byte yields up to three results
//   (byte, carriage return, checksum), drained one per cycle with out_ready high.
//   in_ready is high while the four-entry result queue holds at most one
//   item, so a stalled receiver backs the input up after two results wait.
//   Reset (rst_n low, synchronous) empties the queue, returns the escape
//   machine to plain text and the checksum to 0x7F.
`default_nettype none
module telegram_escape_xor_framer_unit
  import tef_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire tef_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output tef_out_t     out_data
);

  tef_push_t  push;
  tef_qstat_t qstat;
  logic       in_fire;

  // Accept only with room for a full telegram ending
  assign in_ready = (qstat.level <= LEVEL_W'(QUEUE_DEPTH - MAX_RESULTS));
  assign in_fire  = in_valid && in_ready;

  tef_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .in_item (in_data),
    .push    (push)
  );

  tef_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (qstat)
  );

  // Queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.level <= LEVEL_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  // A last byte always closes with the checksum in its final result
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last_byte) |->
      (push.cnt != '0) && push.item[push.cnt - CNT_W'(1)].end_of_telegram)
    else $error("telegram end without checksum byte");

  // Other bytes give at most one ordinary result
  a_mid_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_data.last_byte) |->
      (push.cnt <= 2'd1) && !(push.cnt == 2'd1 && push.item[0].end_of_telegram))
    else $error("unexpected results for a mid-text byte");

  // No results without an accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |-> (push.cnt == '0))
    else $error("results pushed without an accepted item");

endmodule
`default_nettype wire

// ===== hw/rtl/tef_step.sv =====
// Escape/checksum state and the per-item result builder.
`default_nettype none
module tef_step
  import tef_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire tef_in_t   in_item,
  output tef_push_t      push
);

  tef_state_t state_r, state_nxt;
  tef_feed_t  f_text, f_cr;
  tef_push_t  res;
  logic [CNT_W-1:0] n;

  // Text byte, then the closing carriage return on the last byte
  always_comb begin
    f_text = feed(state_r, in_item.text_byte);
    f_cr   = feed(f_text.st, CH_CR);
  end

  // Pack the results of this item to the front of the list
  always_comb begin
    res  = '0;
    n    = '0;
    if (f_text.emit) begin
      res.item[n] = '{out_byte: f_text.value, end_of_telegram: 1'b0};
      n           = n + CNT_W'(1);
    end
    if (in_item.last_byte) begin
      if (f_cr.emit) begin
        res.item[n] = '{out_byte: f_cr.value, end_of_telegram: 1'b0};
        n           = n + CNT_W'(1);
      end
      res.item[n] = '{out_byte: f_cr.st.running_checksum, end_of_telegram: 1'b1};
      n           = n + CNT_W'(1);
    end
    res.cnt = fire ? n : '0;
    push    = res;
  end

  // State update on accept; a finished telegram restarts from reset values
  always_comb begin
    state_nxt = state_r;
    if (fire) state_nxt = in_item.last_byte ? STATE_RESET : f_text.st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= STATE_RESET;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tef_queue.sv =====
// Small result queue: takes up to three items per cycle, hands out one per cycle while out_ready is high.
`default_nettype none
module tef_queue
  import tef_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire tef_push_t push,
  output logic           out_valid,
  input  wire logic      out_ready,
  output tef_out_t       out_data,
  output tef_qstat_t     stat
);

  tef_out_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               pop;

  assign out_valid  = (level_r != '0);
  assign out_data   = mem_r[rd_ptr_r];
  assign pop        = out_valid && out_ready;
  assign stat.level = level_r;

  // Pointer and fill level bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    level_nxt  = level_r + LEVEL_W'(push.cnt) - LEVEL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Entry writes, no reset needed
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (CNT_W'(k) < push.cnt) mem_r[wr_ptr_r + QPTR_W'(k)] <= push.item[k];
    end
  end

endmodule
`default_nettype wire
